FILE: design/afbt_pkg.sv
`default_nettype none
package afbt_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int OCC_W         = IDX_W + 1;

    localparam int KEY_W   = 32;
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 16;
    localparam int BASE_W  = 16;
    localparam int SHIFT_W = 4;
    localparam int BK_W    = BASE_W + (1 << SHIFT_W) - 1;

    localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(250);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(7);

    // configuration register indexes
    localparam logic CFG_BASE_BACKOFF = 1'b0;
    localparam logic CFG_MAX_SHIFT    = 1'b1;

    // operation codes
    localparam logic OP_FAILURE = 1'b0;
    localparam logic OP_SUCCESS = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  retry;
        logic [COUNT_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

FILE: design/afbt_ram.sv
`default_nettype none
module afbt_ram #(
    parameter int AW = 10,
    parameter int DW = 97
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [(1 << AW)];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: design/auth_failure_backoff_table_core.sv
`default_nettype none
// Failed-authentication backoff table.
// Input channel (i_in_valid / o_in_stall): one event per transaction, operation
// (0 failure, 1 success), peer key and current time in ms. Output channel
// (o_out_valid / i_out_stall): exactly one result transaction per event.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 base
// backoff, index 1 max shift; write only while the block is idle.
// All table state lives in one 1024-entry memory (registered read),
// walked one entry per cycle by a read-modify-write sequencer; each event
// takes one or more sequential passes over the memory:
//   success event             : one lookup scan
//   failure, table not full   : one lookup scan
//   failure, table full       : prune scan, then, if still full, max scan
//                               and evict, then lookup scan
// One event is in flight at a time; o_in_stall is high while it is being
// processed, so a new event is taken only after the previous result has
// entered the output register. After reset a clearing pass writes every
// entry invalid; input is stalled during that pass, config writes are taken.
// The result sits in an output register; if the receiver stalls it holds,
// and the sequencer waits before presenting the next result.
module auth_failure_backoff_table_core
    import afbt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // event input
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_operation,
    input  wire logic [KEY_W-1:0]    i_peer_key,
    input  wire logic [TIME_W-1:0]   i_now_ms,
    // result output
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_throttled,
    output logic [COUNT_W-1:0]       o_fail_count,
    output logic [TIME_W-1:0]        o_retry_time_ms,
    output logic                     o_entry_removed,
    // config write
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_index,
    input  wire logic [BASE_W-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PRUNE,
        S_MAX,
        S_EVICT,
        S_FIND,
        S_UPDATE,
        S_OUT
    } t_state;

    localparam logic [OCC_W-1:0] FULL     = OCC_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state              r_state;
    logic [IDX_W-1:0]    r_clr;
    logic [OCC_W-1:0]    r_occ;
    logic [BASE_W-1:0]   r_base;
    logic [SHIFT_W-1:0]  r_max_shift;

    // event being processed
    logic                r_op;
    logic [KEY_W-1:0]    r_key;
    logic [TIME_W-1:0]   r_now;

    // scan pipeline
    logic [OCC_W-1:0]    r_issue_cnt;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;

    // scan results
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    t_entry              r_hit_data;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_free_idx;
    logic                r_vic_found;
    logic [IDX_W-1:0]    r_vic_idx;
    logic [TIME_W-1:0]   r_vic_retry;

    // pending result
    logic                r_res_thr;
    logic [COUNT_W-1:0]  r_res_cnt;
    logic [TIME_W-1:0]   r_res_rt;
    logic                r_res_rem;

    // output register
    logic                r_out_valid;
    logic                r_out_thr;
    logic [COUNT_W-1:0]  r_out_cnt;
    logic [TIME_W-1:0]   r_out_rt;
    logic                r_out_rem;

    // memory ports
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    t_entry              rd_entry;
    logic                scanning;
    logic                rd_last;
    logic                prune_hit;
    logic [OCC_W-1:0]    occ_after_prune;
    logic                key_match;

    // update arithmetic
    t_entry              cur_e;
    t_entry              new_e;
    logic                thr;
    logic [COUNT_W-1:0]  cnt_inc;
    logic [COUNT_W-1:0]  sh_full;
    logic [SHIFT_W-1:0]  sh;
    logic [BK_W-1:0]     backoff;
    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   t_new;
    logic [IDX_W-1:0]    upd_idx;

    logic                in_accept;
    logic                out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_throttled     = r_out_thr;
    assign o_fail_count    = r_out_cnt;
    assign o_retry_time_ms = r_out_rt;
    assign o_entry_removed = r_out_rem;

    afbt_ram #(
        .AW (IDX_W),
        .DW (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // read side: one address per cycle during a scan
    assign scanning = (r_state == S_PRUNE) || (r_state == S_MAX) || (r_state == S_FIND);
    assign rd_en    = scanning && (r_issue_cnt < FULL);
    assign rd_addr  = r_issue_cnt[IDX_W-1:0];
    assign rd_entry = t_entry'(rd_data);
    assign rd_last  = r_rd_vld && (r_rd_idx == LAST_IDX);

    assign prune_hit = (r_state == S_PRUNE) && r_rd_vld && rd_entry.valid
                       && (rd_entry.retry <= r_now);
    assign occ_after_prune = r_occ - OCC_W'(prune_hit);
    assign key_match = r_rd_vld && rd_entry.valid && (rd_entry.key == r_key);

    // failure update of the found or fresh entry
    always_comb begin
        cur_e = r_hit ? r_hit_data : t_entry'{valid: 1'b1, key: r_key, retry: '0, count: '0};
        thr   = r_now < cur_e.retry;
        cnt_inc = (cur_e.count == '1) ? cur_e.count : cur_e.count + COUNT_W'(1);
        sh_full = cnt_inc - COUNT_W'(1);
        sh = (sh_full > COUNT_W'(r_max_shift)) ? r_max_shift : sh_full[SHIFT_W-1:0];
        backoff = BK_W'(r_base) << sh;
        sum = {1'b0, r_now} + (TIME_W + 1)'(backoff);
        t_new = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        new_e = cur_e;
        if (!thr) begin
            new_e.count = cnt_inc;
            new_e.retry = t_new;
        end
        upd_idx = r_hit ? r_hit_idx : r_free_idx;
    end

    // write side
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_idx;
        wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
            end
            S_PRUNE: begin
                wr_en = prune_hit;
            end
            S_EVICT: begin
                wr_en   = r_vic_found;
                wr_addr = r_vic_idx;
            end
            S_UPDATE: begin
                if (r_op == OP_SUCCESS) begin
                    wr_en   = r_hit;
                    wr_addr = r_hit_idx;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = upd_idx;
                    wr_data = ENTRY_W'(new_e);
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_occ       <= '0;
            r_base      <= BASE_RESET;
            r_max_shift <= SHIFT_RESET;
            r_rd_vld    <= 1'b0;
            r_issue_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            r_rd_idx <= rd_addr;
            if (rd_en) begin
                r_issue_cnt <= r_issue_cnt + OCC_W'(1);
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BASE_BACKOFF: r_base      <= i_cfg_data;
                    CFG_MAX_SHIFT:    r_max_shift <= i_cfg_data[SHIFT_W-1:0];
                    default:          r_base      <= r_base;
                endcase
            end

            // output register: load a new result or drain the accepted one
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
                r_out_thr   <= r_res_thr;
                r_out_cnt   <= r_res_cnt;
                r_out_rt    <= r_res_rt;
                r_out_rem   <= r_res_rem;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_op         <= i_operation;
                        r_key        <= i_peer_key;
                        r_now        <= i_now_ms;
                        r_issue_cnt  <= '0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_vic_found  <= 1'b0;
                        if (i_operation == OP_FAILURE && r_occ == FULL) begin
                            r_state <= S_PRUNE;
                        end else begin
                            r_state <= S_FIND;
                        end
                    end
                end
                S_PRUNE: begin
                    r_occ <= occ_after_prune;
                    if (rd_last) begin
                        r_issue_cnt <= '0;
                        r_state     <= (occ_after_prune == FULL) ? S_MAX : S_FIND;
                    end
                end
                S_MAX: begin
                    if (r_rd_vld && rd_entry.valid
                        && (!r_vic_found || rd_entry.retry > r_vic_retry)) begin
                        r_vic_found <= 1'b1;
                        r_vic_idx   <= r_rd_idx;
                        r_vic_retry <= rd_entry.retry;
                    end
                    if (rd_last) begin
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    if (r_vic_found) begin
                        r_occ <= r_occ - OCC_W'(1);
                    end
                    r_issue_cnt <= '0;
                    r_state     <= S_FIND;
                end
                S_FIND: begin
                    if (key_match) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_rd_idx;
                        r_hit_data <= rd_entry;
                    end
                    if (r_rd_vld && !rd_entry.valid && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_rd_idx;
                    end
                    if (rd_last) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_op == OP_SUCCESS) begin
                        r_res_thr <= 1'b0;
                        r_res_cnt <= '0;
                        r_res_rt  <= '0;
                        r_res_rem <= r_hit;
                        if (r_hit) begin
                            r_occ <= r_occ - OCC_W'(1);
                        end
                    end else begin
                        r_res_thr <= thr;
                        r_res_cnt <= new_e.count;
                        r_res_rt  <= new_e.retry;
                        r_res_rem <= 1'b0;
                        if (!r_hit) begin
                            r_occ <= r_occ + OCC_W'(1);
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL)
        else $error("occupancy above table size");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr_en)
        else $error("table written while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("second event taken while busy");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_throttled && o_entry_removed))
        else $error("result both throttled and removed");

endmodule
`default_nettype wire

FILE: verif/afbt_checker.sv
`timescale 1ns / 1ps
module afbt_checker
    import afbt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic               i_operation,
    input  wire logic [KEY_W-1:0]   i_peer_key,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic               i_throttled,
    input  wire logic [COUNT_W-1:0] i_fail_count,
    input  wire logic [TIME_W-1:0]  i_retry_time_ms,
    input  wire logic               i_entry_removed,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [BASE_W-1:0]  i_cfg_data,
    output int                      o_mismatches,
    output int                      o_pending
);

    typedef struct packed {
        logic               throttled;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  retry;
        logic               removed;
    } t_verdict;

    localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF_FFFF;

    bit                 peer_live  [TABLE_ENTRIES];
    logic [KEY_W-1:0]   peer_key   [TABLE_ENTRIES];
    logic [TIME_W-1:0]  peer_retry [TABLE_ENTRIES];
    logic [COUNT_W-1:0] peer_count [TABLE_ENTRIES];
    int                 live_peers;
    logic [BASE_W-1:0]  base_ms;
    logic [SHIFT_W-1:0] shift_cap;
    t_verdict           verdict_q[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic int lookup_peer(logic [KEY_W-1:0] k);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (peer_live[i] && peer_key[i] == k) return i;
        return -1;
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    task automatic predict_event(logic op, logic [KEY_W-1:0] k, logic [TIME_W-1:0] t);
        t_verdict v;
        int s;
        int victim;
        int sh;
        longint unsigned due;
        v = '0;
        if (op == OP_SUCCESS) begin
            s = lookup_peer(k);
            if (s >= 0) begin
                peer_live[s] = 0;
                live_peers--;
                v.removed = 1'b1;
            end
        end else begin
            // full table: prune expired peers, then evict the latest retry
            if (live_peers == TABLE_ENTRIES) begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (peer_live[i] && peer_retry[i] <= t) begin
                        peer_live[i] = 0;
                        live_peers--;
                    end
                if (live_peers == TABLE_ENTRIES) begin
                    victim = 0;
                    for (int i = 1; i < TABLE_ENTRIES; i++)
                        if (peer_retry[i] > peer_retry[victim]) victim = i;
                    peer_live[victim] = 0;
                    live_peers--;
                end
            end
            s = lookup_peer(k);
            if (s < 0) begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (!peer_live[i]) begin
                        s = i;
                        break;
                    end
                live_peers++;
                peer_live[s]  = 1;
                peer_key[s]   = k;
                peer_retry[s] = '0;
                peer_count[s] = '0;
            end
            if (t < peer_retry[s]) begin
                v.throttled = 1'b1;
            end else begin
                if (peer_count[s] != '1) peer_count[s]++;
                sh = int'(peer_count[s]) - 1;
                if (sh > int'(shift_cap)) sh = int'(shift_cap);
                due = longint'(t) + (longint'(base_ms) << sh);
                if (due > TIME_MAX) due = TIME_MAX;
                peer_retry[s] = due[TIME_W-1:0];
            end
            v.count = peer_count[s];
            v.retry = peer_retry[s];
        end
        verdict_q.push_back(v);
    endtask

    always @(posedge i_clk) begin
        t_verdict w;
        if (!i_rst_n) begin
            foreach (peer_live[i]) peer_live[i] = 0;
            live_peers = 0;
            base_ms    = BASE_RESET;
            shift_cap  = SHIFT_RESET;
            verdict_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    w = verdict_q.pop_front();
                    if (i_throttled !== w.throttled)
                        report("throttled", i_throttled, w.throttled);
                    if (i_fail_count !== w.count)
                        report("fail_count", i_fail_count, w.count);
                    if (i_retry_time_ms !== w.retry)
                        report("retry_time_ms", i_retry_time_ms, w.retry);
                    if (i_entry_removed !== w.removed)
                        report("entry_removed", i_entry_removed, w.removed);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_BASE_BACKOFF) base_ms = i_cfg_data;
                else shift_cap = i_cfg_data[SHIFT_W-1:0];
            end
            if (i_in_valid && !i_in_stall)
                predict_event(i_operation, i_peer_key, i_now_ms);
        end
        o_pending = verdict_q.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import afbt_pkg::*;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               operation = OP_FAILURE;
    logic [KEY_W-1:0]   peer      = '0;
    logic [TIME_W-1:0]  now_ms    = '0;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_index = CFG_BASE_BACKOFF;
    logic [BASE_W-1:0]  cfg_data  = '0;

    wire logic               in_stall;
    wire logic               out_valid;
    wire logic               throttled;
    wire logic [COUNT_W-1:0] fail_count;
    wire logic [TIME_W-1:0]  retry_time;
    wire logic               entry_removed;
    wire logic               cfg_ready;
    int                      mismatches;
    int                      pending;

    // percent of cycles the sender idles / the receiver stalls
    int idle_pct  = 0;
    int stall_pct = 0;

    // keys already offered to the table, reused to hit existing entries
    logic [KEY_W-1:0] known_keys[$];
    longint unsigned  clock_ms;

    always #5 clk = ~clk;

    auth_failure_backoff_table_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_operation     (operation),
        .i_peer_key      (peer),
        .i_now_ms        (now_ms),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_throttled     (throttled),
        .o_fail_count    (fail_count),
        .o_retry_time_ms (retry_time),
        .o_entry_removed (entry_removed),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    afbt_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_operation     (operation),
        .i_peer_key      (peer),
        .i_now_ms        (now_ms),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_throttled     (throttled),
        .i_fail_count    (fail_count),
        .i_retry_time_ms (retry_time),
        .i_entry_removed (entry_removed),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

    // one event transaction; valid stays high on return so back-to-back
    // events go out without a bubble
    task automatic post_event(logic op, logic [KEY_W-1:0] k, logic [TIME_W-1:0] t);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        peer      <= k;
        now_ms    <= t;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        known_keys.push_back(k);
    endtask

    // drop valid and wait for every result; the block is idle once the
    // last result is out
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [BASE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // random event: known peers, a few hot keys or a fresh random key, time creeping
    // forward with occasional stale timestamps to provoke throttling
    task automatic random_event();
        logic             op;
        logic [KEY_W-1:0] k;
        logic [TIME_W-1:0] t;
        int               r;
        op = ($urandom_range(3) == 0) ? OP_SUCCESS : OP_FAILURE;
        r  = $urandom_range(99);
        if (r < 45)      k = known_keys[$urandom_range(known_keys.size() - 1)];
        else if (r < 70) k = KEY_W'(32'h0000_00A0 + $urandom_range(3));
        else             k = $urandom;
        r = $urandom_range(99);
        if (r < 70) begin
            clock_ms += $urandom_range(300);
            t = clock_ms[TIME_W-1:0];
        end else if (r < 90) begin
            clock_ms += $urandom_range(5000);
            t = clock_ms[TIME_W-1:0];
        end else begin
            t = TIME_W'(clock_ms - $urandom_range(2000));
        end
        post_event(op, k, t);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset config, throttle, success erase and miss
        post_event(OP_FAILURE, 32'h0, 48'h0);
        post_event(OP_FAILURE, 32'h0, 48'h0);
        post_event(OP_FAILURE, 32'h0, 48'd250);
        post_event(OP_SUCCESS, 32'h0, 48'd1);
        post_event(OP_SUCCESS, 32'h0, 48'd1);
        // retry time clamps at the top of the 48-bit range
        post_event(OP_FAILURE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        post_event(OP_FAILURE, 32'h8000_0001, 48'hFFFF_FFFF_FF00);

        // zero base: retry equals now, so an immediate repeat is not throttled
        settle();
        write_reg(CFG_BASE_BACKOFF, 16'h0000);
        post_event(OP_FAILURE, 32'h7, 48'd100);
        post_event(OP_FAILURE, 32'h7, 48'd100);

        // largest base and shift, walk the exponent up to its cap
        settle();
        write_reg(CFG_BASE_BACKOFF, 16'hFFFF);
        write_reg(CFG_MAX_SHIFT, 16'h000F);
        for (int i = 0; i < 16; i++)
            post_event(OP_FAILURE, 32'h9, TIME_W'(longint'(i + 1) << 33));
        settle();
        write_reg(CFG_MAX_SHIFT, 16'h0000);
        post_event(OP_FAILURE, 32'h9, TIME_W'(longint'(17) << 33));

        clock_ms = 64'h1_0000_0000;

        // random phases: each with its own config and idle pattern
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                    write_reg(CFG_BASE_BACKOFF, 16'd250);
                    write_reg(CFG_MAX_SHIFT, 16'd7);
                end
                1: begin
                    idle_pct = 66; stall_pct = 0;
                    write_reg(CFG_BASE_BACKOFF, 16'd1);
                    write_reg(CFG_MAX_SHIFT, 16'h000F);
                end
                2: begin
                    idle_pct = 0;  stall_pct = 66;
                    write_reg(CFG_BASE_BACKOFF, 16'hFFFF);
                    write_reg(CFG_MAX_SHIFT, 16'h0000);
                end
                default: begin
                    idle_pct = 28; stall_pct = 28;
                    write_reg(CFG_BASE_BACKOFF, BASE_W'($urandom_range(65535, 1)));
                    write_reg(CFG_MAX_SHIFT, BASE_W'($urandom_range(15)));
                end
            endcase
            for (int n = 0; n < 66; n++) begin
                // hold off mid-phase until the block has drained
                if (ph == 1 && n == 33) settle();
                random_event();
            end
        end

        in_valid <= 1'b0;
        for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #100_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
